### hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared types, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int StackDepth = 16;
    localparam int PtrW       = $clog2(StackDepth);
    localparam int CountW     = $clog2(StackDepth + 1);

    localparam logic signed [63:0] QMax = 64'sd2147483647;
    localparam logic signed [63:0] QMin = -64'sd2147483648;

    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_SQRT   = 4'd5,
        OP_DROP   = 4'd6,
        OP_CLEAR  = 4'd7,
        OP_STORE  = 4'd8,
        OP_MCLEAR = 4'd9,
        OP_RECALL = 4'd10
    } opcode_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_NEGROOT = 3'd4;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic               top_valid;
        logic [4:0]         stack_depth;
        logic [2:0]         status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDTOP,
        S_LDTOP,
        S_RDELEM,
        S_LDELEM,
        S_EXEC,
        S_WAIT,
        S_WRITE,
        S_RESP
    } ctrl_state_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD_R,
        DP_START,
        DP_WRITE_R,
        DP_WRITE_IN,
        DP_WRITE_MEM
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [PtrW-1:0] addr;
        logic [2:0]      alu_op;
        logic            mem_store;
        logic            mem_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic               busy;
        logic               divzero;
        logic               negroot;
        logic signed [31:0] r;
    } dp_stat_t;

endpackage

### hdl/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Push, recall, drop, store and memory clear read the top of a non-empty stack
// back before the result beat; clear all and a refused op go straight to it.
// A fold loads the top, then reads and combines each value below it in turn;
// a zero divisor ends a divide step early. Root ends early on a negative value.
// One beat is in flight at a time; the next input beat can be taken in the
// cycle after the result beat. Reset clears count, memory and control.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core
    import rpn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [CountW-1:0] count;
    logic [2:0]        status;

    rpn_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_opcode (in_data.opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    rpn_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_value (in_data.operand_value),
        .stat     (stat)
    );

    assign out_data.top_value   = (count != '0) ? stat.r : 32'sd0;
    assign out_data.top_valid   = (count != '0);
    assign out_data.stack_depth = 5'(count);
    assign out_data.status      = status;

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CountW'(StackDepth))
        else $error("stack count above depth");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_valid_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.top_valid == (count != '0)))
        else $error("top valid mismatch");

endmodule

### hdl/rpn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/rpn_datapath.sv
// ----------------------------------------------------------------------------
// RPN datapath
// Running result register, iterative multiply, divide and root unit, stack RAM.
// ----------------------------------------------------------------------------
module rpn_datapath
    import rpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] in_value,
    output dp_stat_t           stat
);

    logic signed [31:0] ram_rdata;
    logic               ram_we;
    logic [31:0]        ram_wdata;
    logic signed [31:0] r_reg, r_next;
    logic signed [31:0] e_reg, e_next;
    logic signed [31:0] mem_reg, mem_next;
    logic [2:0]         op_reg, op_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               dz_reg, dz_next;
    logic               nr_reg, nr_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        aux_reg, aux_next;
    logic [63:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;

    logic signed [64:0] sum65;
    logic signed [63:0] prod;
    logic [63:0]        trial;
    logic [64:0]        rem_sh;
    logic [63:0]        q_mag;
    logic signed [64:0] q_signed;
    logic [63:0]        root_rem;
    logic [63:0]        root_try;

    rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (ram_wdata),
        .raddr (cmd.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = r_reg;
        unique case (cmd.op)
            DP_WRITE_R:
            begin
                ram_we = 1'b1;
            end
            DP_WRITE_IN:
            begin
                ram_we    = 1'b1;
                ram_wdata = in_value;
            end
            DP_WRITE_MEM:
            begin
                ram_we    = 1'b1;
                ram_wdata = mem_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sum65    = 65'sd0;
        prod     = $signed(acc_reg);
        trial    = 64'd0;
        rem_sh   = {aux_reg, quo_reg[63]};
        q_mag    = 64'd0;
        q_signed = 65'sd0;
        root_rem = 64'd0;
        root_try = 64'd0;
        r_next   = r_reg;
        e_next   = e_reg;
        mem_next = mem_reg;
        op_next  = op_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        dz_next  = dz_reg;
        nr_next  = nr_reg;
        acc_next = acc_reg;
        aux_next = aux_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;

        if (cmd.mem_clear)
        begin
            mem_next = '0;
        end
        else if (cmd.mem_store)
        begin
            mem_next = r_reg;
        end

        unique case (cmd.op)
            DP_LOAD_R:
            begin
                r_next  = ram_rdata;
                dz_next = 1'b0;
                nr_next = 1'b0;
            end
            DP_START:
            begin
                e_next    = ram_rdata;
                op_next   = cmd.alu_op;
                busy_next = 1'b1;
                cnt_next  = '0;
                acc_next  = 64'd0;
                aux_next  = 64'd0;
                quo_next  = 64'd0;
                neg_next  = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (busy_reg)
        begin
            unique case (op_reg)
                3'(OP_ADD), 3'(OP_SUB):
                begin
                    if (op_reg == 3'(OP_ADD))
                        sum65 = 65'(e_reg) + 65'(r_reg);
                    else
                        sum65 = 65'(e_reg) - 65'(r_reg);
                    if (sum65 > 65'(QMax))
                        r_next = 32'(QMax);
                    else if (sum65 < 65'(QMin))
                        r_next = 32'(QMin);
                    else
                        r_next = sum65[31:0];
                    busy_next = 1'b0;
                end
                3'(OP_MUL):
                begin
                    // First the 32x32 product, then shift and saturate.
                    if (cnt_reg == 7'd0)
                    begin
                        acc_next = 64'($signed(e_reg) * $signed(r_reg));
                        cnt_next = 7'd1;
                    end
                    else
                    begin
                        // Arithmetic shift floors toward minus infinity.
                        prod = $signed(acc_reg) >>> 16;
                        if (prod > QMax)
                            r_next = 32'(QMax);
                        else if (prod < QMin)
                            r_next = 32'(QMin);
                        else
                            r_next = prod[31:0];
                        busy_next = 1'b0;
                    end
                end
                3'(OP_DIV):
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        if (r_reg == 32'sd0)
                        begin
                            dz_next = 1'b1;
                            if (e_reg > 32'sd0)
                                r_next = 32'(QMax);
                            else if (e_reg < 32'sd0)
                                r_next = 32'(QMin);
                            else
                                r_next = 32'sd0;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            neg_next = e_reg[31] ^ r_reg[31];
                            quo_next = {(e_reg[31] ? 32'(-e_reg) : 32'(e_reg)), 32'd0};
                            acc_next = {32'd0, (r_reg[31] ? 32'(-r_reg) : 32'(r_reg))};
                            aux_next = 64'd0;
                            cnt_next = 7'd1;
                        end
                    end
                    else if (cnt_reg <= 7'd48)
                    begin
                        // Restoring division, one quotient bit a cycle.
                        trial = rem_sh[63:0] - acc_reg;
                        if (rem_sh >= {1'b0, acc_reg})
                        begin
                            aux_next = trial;
                            quo_next = {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            aux_next = rem_sh[63:0];
                            quo_next = {quo_reg[62:0], 1'b0};
                        end
                        cnt_next = cnt_reg + 7'd1;
                    end
                    else
                    begin
                        q_mag    = {16'd0, quo_reg[47:0]};
                        q_signed = neg_reg ? -$signed({1'b0, q_mag})
                                           : $signed({1'b0, q_mag});
                        if (q_signed > 65'(QMax))
                            r_next = 32'(QMax);
                        else if (q_signed < 65'(QMin))
                            r_next = 32'(QMin);
                        else
                            r_next = q_signed[31:0];
                        busy_next = 1'b0;
                    end
                end
                3'(OP_SQRT):
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        if (r_reg[31])
                        begin
                            r_next    = 32'sd0;
                            nr_next   = 1'b1;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            acc_next = {16'd0, r_reg, 16'd0};
                            aux_next = 64'd1 << 62;
                            quo_next = 64'd0;
                            cnt_next = 7'd1;
                        end
                    end
                    else if (aux_reg != 64'd0)
                    begin
                        root_try = quo_reg + aux_reg;
                        root_rem = acc_reg;
                        if (root_rem >= root_try)
                        begin
                            acc_next = root_rem - root_try;
                            quo_next = (quo_reg >> 1) + aux_reg;
                        end
                        else
                        begin
                            quo_next = quo_reg >> 1;
                        end
                        aux_next = aux_reg >> 2;
                    end
                    else
                    begin
                        r_next    = quo_reg[31:0];
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mem_reg  <= '0;
            dz_reg   <= 1'b0;
            nr_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            mem_reg  <= mem_next;
            dz_reg   <= dz_next;
            nr_reg   <= nr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        e_reg   <= e_next;
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        aux_reg <= aux_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.divzero = dz_reg;
    assign stat.negroot = nr_reg;
    assign stat.r       = r_reg;

endmodule

### hdl/rpn_controller.sv
// ----------------------------------------------------------------------------
// RPN controller
// Sequences stack reads, fold and root steps and write back, and holds the count.
// ----------------------------------------------------------------------------
module rpn_controller
    import rpn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          in_opcode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CountW-1:0]   count,
    output logic [2:0]          status,
    output dp_cmd_t             cmd,
    input  dp_stat_t            stat
);

    ctrl_state_t       state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [3:0]        op_reg, op_next;
    logic [2:0]        status_reg, status_next;
    logic              fold_op;
    logic              empty;

    assign empty   = (count_reg == '0);
    assign fold_op = (op_reg == OP_ADD) || (op_reg == OP_SUB) ||
                     (op_reg == OP_MUL) || (op_reg == OP_DIV);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_opcode;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    priority case (in_opcode)
                        OP_PUSH, OP_RECALL:
                        begin
                            if (count_reg >= CountW'(StackDepth))
                                status_next = ST_FULL;
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_STORE:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                                state_next = S_RDTOP;
                            idx_next = count_reg - 1'b1;
                        end
                        OP_DROP:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (count_next != '0 && status_next == ST_OK &&
                        state_next == S_RESP)
                    begin
                        idx_next = count_next - 1'b1;
                        state_next = S_RDTOP;
                    end
                end
            end
            S_RDTOP:
            begin
                state_next = S_LDTOP;
            end
            S_LDTOP:
            begin
                if (fold_op && idx_reg != '0)
                    state_next = S_RDELEM;
                else if (op_reg == OP_SQRT)
                    state_next = S_EXEC;
                else
                    state_next = S_RESP;
            end
            S_RDELEM:
            begin
                idx_next   = idx_reg - 1'b1;
                state_next = S_LDELEM;
            end
            S_LDELEM:
            begin
                state_next = S_WAIT;
            end
            S_EXEC:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    if (fold_op && idx_reg != '0)
                        state_next = S_RDELEM;
                    else
                        state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (fold_op)
                    count_next = CountW'(1);
                if (stat.divzero)
                    status_next = ST_DIVZERO;
                else if (stat.negroot)
                    status_next = ST_NEGROOT;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.op        = DP_NONE;
        cmd.addr      = idx_reg[PtrW-1:0];
        cmd.alu_op    = op_reg[2:0];
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.addr = count_reg[PtrW-1:0];
                if (in_valid)
                begin
                    if (in_opcode == OP_PUSH && count_reg < CountW'(StackDepth))
                        cmd.op = DP_WRITE_IN;
                    else if (in_opcode == OP_RECALL && count_reg < CountW'(StackDepth))
                        cmd.op = DP_WRITE_MEM;
                    cmd.mem_clear = (in_opcode == OP_CLEAR) || (in_opcode == OP_MCLEAR);
                end
            end
            S_LDTOP:
            begin
                cmd.op        = DP_LOAD_R;
                cmd.mem_store = 1'b0;
            end
            S_RDELEM:
            begin
                cmd.addr = idx_reg[PtrW-1:0] - 1'b1;
            end
            S_LDELEM:
            begin
                cmd.op = DP_START;
            end
            S_EXEC:
            begin
                cmd.op = DP_START;
            end
            S_WRITE:
            begin
                cmd.op   = DP_WRITE_R;
                cmd.addr = fold_op ? '0 : idx_reg[PtrW-1:0];
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                cmd.mem_store = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_RESP && op_reg == OP_STORE && status_reg == ST_OK &&
            out_ready)
            cmd.mem_store = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            op_reg     <= OP_PUSH;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;

endmodule

### test/rpn_stack_calculator_core_checker.sv
// ----------------------------------------------------------------------------
// RPN calculator result checker
// Watches both channels, keeps its own copy of the stack and memory, predicts
// each result beat and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core_checker
    import rpn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_count
);

    logic signed [31:0] calc_stack [StackDepth];
    int                 calc_depth;
    logic signed [31:0] calc_memory;
    out_item_t          expected_results [$];

    function automatic logic signed [63:0] clamp_q(logic signed [63:0] v);
        if (v > QMax) return QMax;
        if (v < QMin) return QMin;
        return v;
    endfunction

    function automatic logic signed [63:0] q_product(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clamp_q(p >>> 16);
    endfunction

    function automatic logic [31:0] q_root(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [2:0] fold_stack(opcode_t op);
        logic signed [63:0] r;
        logic signed [63:0] e;
        logic               dz;
        dz = 1'b0;
        if (calc_depth == 0) return ST_EMPTY;
        r = calc_stack[calc_depth-1];
        for (int i = calc_depth - 1; i > 0; i--)
        begin
            e = calc_stack[i-1];
            case (op)
                OP_ADD: r = clamp_q(e + r);
                OP_SUB: r = clamp_q(e - r);
                OP_MUL: r = q_product(e, r);
                default:
                begin
                    if (r == 0)
                    begin
                        dz = 1'b1;
                        r = (e > 0) ? QMax : (e < 0) ? QMin : 64'sd0;
                    end
                    else
                        r = clamp_q((e * 64'sd65536) / r);
                end
            endcase
        end
        calc_stack[0] = r[31:0];
        calc_depth = 1;
        return dz ? ST_DIVZERO : ST_OK;
    endfunction

    function automatic logic [2:0] push_value(logic signed [31:0] v);
        if (calc_depth >= StackDepth) return ST_FULL;
        calc_stack[calc_depth] = v;
        calc_depth++;
        return ST_OK;
    endfunction

    function automatic out_item_t predict_step(in_item_t item);
        out_item_t  res;
        logic [2:0] st;
        st = ST_OK;
        case (item.opcode)
            OP_PUSH: st = push_value(item.operand_value);
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: st = fold_stack(opcode_t'(item.opcode));
            OP_SQRT:
            begin
                if (calc_depth == 0) st = ST_EMPTY;
                else if (calc_stack[calc_depth-1] < 0)
                begin
                    calc_stack[calc_depth-1] = 0;
                    st = ST_NEGROOT;
                end
                else
                    calc_stack[calc_depth-1] =
                        q_root({32'd0, calc_stack[calc_depth-1]} << 16);
            end
            OP_DROP:
            begin
                if (calc_depth == 0) st = ST_EMPTY;
                else calc_depth--;
            end
            OP_CLEAR:
            begin
                calc_depth = 0;
                calc_memory = 0;
            end
            OP_STORE:
            begin
                if (calc_depth == 0) st = ST_EMPTY;
                else calc_memory = calc_stack[calc_depth-1];
            end
            OP_MCLEAR: calc_memory = 0;
            OP_RECALL: st = push_value(calc_memory);
            default: st = ST_OK;
        endcase
        res.top_valid   = (calc_depth > 0);
        res.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : 32'sd0;
        res.stack_depth = calc_depth[4:0];
        res.status      = st;
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            calc_depth = 0;
            calc_memory = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_step(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.top_value !== out_data.top_value)
                    begin
                        $display("%0t: top_value expected %h actual %h", $time,
                                 exp_item.top_value, out_data.top_value);
                        fail_count++;
                    end
                    if (exp_item.top_valid !== out_data.top_valid)
                    begin
                        $display("%0t: top_valid expected %b actual %b", $time,
                                 exp_item.top_valid, out_data.top_valid);
                        fail_count++;
                    end
                    if (exp_item.stack_depth !== out_data.stack_depth)
                    begin
                        $display("%0t: stack_depth expected %0d actual %0d", $time,
                                 exp_item.stack_depth, out_data.stack_depth);
                        fail_count++;
                    end
                    if (exp_item.status !== out_data.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_item.status, out_data.status);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### test/rpn_stack_calculator_core_tb.sv
// ----------------------------------------------------------------------------
// RPN stack calculator core testbench
// Drives directed corner cases and then random opcode sequences with random
// gaps on both channels; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core_tb;
    import rpn_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_count;
    int        idle_cycles;
    int        sent_count;
    int        stall_left;

    localparam int WatchdogLimit = 20000;

    rpn_stack_calculator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rpn_stack_calculator_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [3:0] op, logic [31:0] val);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data.opcode <= op;
        in_data.operand_value <= val;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= gap_length();
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int          len;
        logic [3:0]  op;
        sent_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_ADD, 0);
        send_beat(OP_SQRT, 0);
        send_beat(OP_DROP, 0);
        send_beat(OP_STORE, 0);
        send_beat(OP_RECALL, 0);
        send_beat(OP_ADD, 0);
        send_beat(OP_PUSH, 32'h7fffffff);
        send_beat(OP_PUSH, 32'h7fffffff);
        send_beat(OP_ADD, 0);
        send_beat(OP_PUSH, 32'h80000000);
        send_beat(OP_SUB, 0);
        send_beat(OP_PUSH, 32'h80000000);
        send_beat(OP_MUL, 0);
        send_beat(OP_PUSH, 0);
        send_beat(OP_DIV, 0);
        send_beat(OP_STORE, 0);
        send_beat(OP_PUSH, 32'hffff0000);
        send_beat(OP_SQRT, 0);
        send_beat(OP_PUSH, 32'h00090000);
        send_beat(OP_SQRT, 0);
        for (int i = 0; i < 16; i++) send_beat(OP_PUSH, $urandom);
        send_beat(OP_RECALL, 0);
        send_beat(OP_MCLEAR, 0);
        send_beat(4'd15, 32'hffffffff);
        send_beat(OP_CLEAR, 0);

        drain_results();

        while (sent_count < 1900)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                op = 4'($urandom_range(0, 15));
                send_beat(op, $urandom);
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 17)
                                                  : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 4) == 0) send_beat(OP_RECALL, 0);
                    else send_beat(OP_PUSH, random_value());
                end
                if ($urandom_range(0, 3) == 0) send_beat(OP_SQRT, 0);
                if ($urandom_range(0, 3) == 0) send_beat(OP_STORE, 0);
                op = 4'($urandom_range(OP_ADD, OP_DIV));
                send_beat(op, $urandom);
                case ($urandom_range(0, 5))
                    0: send_beat(OP_DROP, 0);
                    1: send_beat(OP_CLEAR, 0);
                    2: send_beat(OP_MCLEAR, 0);
                    default: ;
                endcase
            end
            if ($urandom_range(0, 199) == 0) drain_results();
        end

        drain_results();
        repeat (100) @(posedge clk);
        $display("Sent %0d beats: pushes, recalls, folds of all four operators,", sent_count);
        $display("roots, drops, memory ops, unused opcodes and full or empty stacks.");
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### rpn_stack_calculator_core.f
hdl/rpn_pkg.sv
hdl/rpn_ram.sv
hdl/rpn_datapath.sv
hdl/rpn_controller.sv
hdl/rpn_stack_calculator_core.sv
test/rpn_stack_calculator_core_checker.sv
test/rpn_stack_calculator_core_tb.sv
